// File: design/lvbp_pkg.sv
// ----------------------------------------------------------------------------
// lvbp_pkg
// Shared widths, constants, arctangent table and microcode for the leg
// vector from body pose unit.
// ----------------------------------------------------------------------------
package lvbp_pkg;

    localparam int LEG_COUNT    = 4;
    localparam int LEG_W        = 2;
    localparam int ANG_W        = 19;
    localparam int POS_W        = 32;
    localparam int HIP_U_W      = 21;
    localparam int HIP_S_W      = 22;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;
    localparam int TRIG_W       = 34;
    localparam int Z_W          = 35;
    localparam int STEP_W       = 5;
    localparam int CORDIC_STEPS = 24;
    localparam int PROD_W       = 64;
    localparam int ACC_W        = 60;
    localparam int OFF_W        = 35;
    localparam int ROT_W        = ACC_W - 30;
    localparam int DIFF_W       = 36;
    localparam int PC_W         = 5;
    localparam int UCODE_LAST   = 25;

    localparam logic [LEG_W-1:0] LEG_LAST = LEG_W'(LEG_COUNT - 1);

    localparam logic signed [Z_W-1:0]    HALF_PI  = 35'sh006487ED51;
    localparam logic signed [Z_W-1:0]    PI_Q30   = 35'sh00C90FDAA2;
    localparam logic signed [TRIG_W-1:0] GAIN_INV = 34'sh0026DD3B6A;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_HIP_FORWARD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIP_LATERAL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIP_VERTICAL = 2'd2;

    // trig register groups loaded from the cordic
    localparam logic [1:0] TRIG_ROLL  = 2'd0;
    localparam logic [1:0] TRIG_PITCH = 2'd1;
    localparam logic [1:0] TRIG_YAW   = 2'd2;

    typedef enum logic [2:0] {
        SA_CY, SA_SY, SA_CP, SA_SP, SA_T1, SA_T2, SA_TMP
    } sel_a_t;

    typedef enum logic [2:0] {
        SB_SP, SB_CP, SB_SR, SB_CR, SB_HX, SB_HY, SB_HZ
    } sel_b_t;

    typedef enum logic [3:0] {
        ACT_T1, ACT_T2, ACT_SET, ACT_ADD, ACT_SUB,
        ACT_ACC_FIRST, ACT_ACC, ACT_NACC_FIRST,
        ACT_FIN0, ACT_FIN1, ACT_FIN2
    } act_t;

    typedef struct packed {
        sel_a_t a;
        sel_b_t b;
        act_t   act;
    } uop_t;

    typedef struct packed {
        logic mul_en;
        logic act_en;
        uop_t uop;
    } mac_ctrl_t;

    function automatic logic signed [Z_W-1:0] atan_lut(input logic [STEP_W-1:0] i);
        logic signed [Z_W-1:0] r;
        begin
            case (i)
                5'd0:    r = 35'sh03243F6A8;
                5'd1:    r = 35'sh01DAC6705;
                5'd2:    r = 35'sh00FADBAFC;
                5'd3:    r = 35'sh007F56EA6;
                5'd4:    r = 35'sh003FEAB76;
                5'd5:    r = 35'sh001FFD55B;
                5'd6:    r = 35'sh000FFFAAA;
                5'd7:    r = 35'sh0007FFF55;
                5'd8:    r = 35'sh0003FFFEA;
                5'd9:    r = 35'sh0001FFFFD;
                5'd10:   r = 35'sh0000FFFFF;
                5'd11:   r = 35'sh00007FFFF;
                5'd12:   r = 35'sh00003FFFF;
                5'd13:   r = 35'sh00001FFFF;
                5'd14:   r = 35'sh00000FFFF;
                5'd15:   r = 35'sh000007FFF;
                5'd16:   r = 35'sh000003FFF;
                5'd17:   r = 35'sh000001FFF;
                5'd18:   r = 35'sh000000FFF;
                5'd19:   r = 35'sh0000007FF;
                5'd20:   r = 35'sh0000003FF;
                5'd21:   r = 35'sh0000001FF;
                5'd22:   r = 35'sh0000000FF;
                5'd23:   r = 35'sh00000007F;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    // rotation matrix rows, each multiplied into the hip offset
    function automatic uop_t ucode(input logic [PC_W-1:0] pc);
        uop_t u;
        begin
            case (pc)
                5'd0:    u = '{SA_CY,  SB_SP, ACT_T1};
                5'd1:    u = '{SA_SY,  SB_SP, ACT_T2};
                5'd2:    u = '{SA_CY,  SB_CP, ACT_SET};
                5'd3:    u = '{SA_TMP, SB_HX, ACT_ACC_FIRST};
                5'd4:    u = '{SA_T1,  SB_SR, ACT_SET};
                5'd5:    u = '{SA_SY,  SB_CR, ACT_SUB};
                5'd6:    u = '{SA_TMP, SB_HY, ACT_ACC};
                5'd7:    u = '{SA_T1,  SB_CR, ACT_SET};
                5'd8:    u = '{SA_SY,  SB_SR, ACT_ADD};
                5'd9:    u = '{SA_TMP, SB_HZ, ACT_ACC};
                5'd10:   u = '{SA_TMP, SB_HZ, ACT_FIN0};
                5'd11:   u = '{SA_SY,  SB_CP, ACT_SET};
                5'd12:   u = '{SA_TMP, SB_HX, ACT_ACC_FIRST};
                5'd13:   u = '{SA_T2,  SB_SR, ACT_SET};
                5'd14:   u = '{SA_CY,  SB_CR, ACT_ADD};
                5'd15:   u = '{SA_TMP, SB_HY, ACT_ACC};
                5'd16:   u = '{SA_T2,  SB_CR, ACT_SET};
                5'd17:   u = '{SA_CY,  SB_SR, ACT_SUB};
                5'd18:   u = '{SA_TMP, SB_HZ, ACT_ACC};
                5'd19:   u = '{SA_TMP, SB_HZ, ACT_FIN1};
                5'd20:   u = '{SA_SP,  SB_HX, ACT_NACC_FIRST};
                5'd21:   u = '{SA_CP,  SB_SR, ACT_SET};
                5'd22:   u = '{SA_TMP, SB_HY, ACT_ACC};
                5'd23:   u = '{SA_CP,  SB_CR, ACT_SET};
                5'd24:   u = '{SA_TMP, SB_HZ, ACT_ACC};
                5'd25:   u = '{SA_TMP, SB_HZ, ACT_FIN2};
                default: u = '{SA_TMP, SB_HZ, ACT_FIN2};
            endcase
            return u;
        end
    endfunction

endpackage

// File: design/lvbp_if.sv
// ----------------------------------------------------------------------------
// lvbp channel interfaces
// Pose input, leg vector output and configuration write channels.
// ----------------------------------------------------------------------------
interface lvbp_pose_if;
    import lvbp_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [ANG_W-1:0] roll;
    logic signed [ANG_W-1:0] pitch;
    logic signed [ANG_W-1:0] yaw;
    logic signed [POS_W-1:0] shift_x;
    logic signed [POS_W-1:0] shift_y;
    logic signed [POS_W-1:0] shift_z;
    logic signed [POS_W-1:0] base_x;
    logic signed [POS_W-1:0] base_y;
    logic signed [POS_W-1:0] base_z;
    logic signed [POS_W-1:0] foot_x;
    logic signed [POS_W-1:0] foot_y;
    logic signed [POS_W-1:0] foot_z;

    modport source (output valid, roll, pitch, yaw, shift_x, shift_y, shift_z,
                    base_x, base_y, base_z, foot_x, foot_y, foot_z, input ready);
    modport sink (input valid, roll, pitch, yaw, shift_x, shift_y, shift_z,
                  base_x, base_y, base_z, foot_x, foot_y, foot_z, output ready);
endinterface

interface lvbp_leg_if;
    import lvbp_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [LEG_W-1:0]        leg_number;
    logic signed [POS_W-1:0] leg_x;
    logic signed [POS_W-1:0] leg_y;
    logic signed [POS_W-1:0] leg_z;
    logic                    last_leg;
    logic                    clipped;

    modport source (output valid, leg_number, leg_x, leg_y, leg_z, last_leg, clipped,
                    input ready);
    modport sink (input valid, leg_number, leg_x, leg_y, leg_z, last_leg, clipped,
                  output ready);
endinterface

interface lvbp_cfg_if;
    import lvbp_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: design/lvbp_cordic.sv
// ----------------------------------------------------------------------------
// lvbp_cordic
// Iterative rotation-mode cordic, one step a cycle, giving Q4.30 sin and cos.
// ----------------------------------------------------------------------------
module lvbp_cordic
    import lvbp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [ANG_W-1:0]  angle,
    output logic                     done,
    output logic signed [TRIG_W-1:0] sin_val,
    output logic signed [TRIG_W-1:0] cos_val
);

    logic                     run_reg, run_next;
    logic                     done_reg, done_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic signed [TRIG_W-1:0] x_reg, x_next;
    logic signed [TRIG_W-1:0] y_reg, y_next;
    logic signed [Z_W-1:0]    z_reg, z_next;
    logic                     flip_reg, flip_next;
    logic signed [Z_W-1:0]    z_start;
    logic signed [TRIG_W-1:0] xs, ys;
    logic signed [Z_W-1:0]    at;

    assign z_start = Z_W'(angle) <<< 14;
    assign xs      = x_reg >>> step_reg;
    assign ys      = y_reg >>> step_reg;
    assign at      = atan_lut(step_reg);

    // range fold and micro-rotation
    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        step_next = step_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        flip_next = flip_reg;
        if (start)
        begin
            run_next  = 1'b1;
            step_next = '0;
            x_next    = GAIN_INV;
            y_next    = '0;
            if (z_start > HALF_PI)
            begin
                z_next    = z_start - PI_Q30;
                flip_next = 1'b1;
            end
            else if (z_start < -HALF_PI)
            begin
                z_next    = z_start + PI_Q30;
                flip_next = 1'b1;
            end
            else
            begin
                z_next    = z_start;
                flip_next = 1'b0;
            end
        end
        else if (run_reg)
        begin
            if (!z_reg[Z_W-1])
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + at;
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(CORDIC_STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
    end

    assign done    = done_reg;
    assign sin_val = flip_reg ? -y_reg : y_reg;
    assign cos_val = flip_reg ? -x_reg : x_reg;

endmodule

// File: design/lvbp_mac.sv
// ----------------------------------------------------------------------------
// lvbp_mac
// Shared multiplier with trig, scratch and accumulator registers.
// ----------------------------------------------------------------------------
module lvbp_mac
    import lvbp_pkg::*;
(
    input  logic                      clk,
    input  mac_ctrl_t                 ctrl,
    input  logic                      trig_we,
    input  logic [1:0]                trig_sel,
    input  logic signed [TRIG_W-1:0]  sin_val,
    input  logic signed [TRIG_W-1:0]  cos_val,
    input  logic signed [HIP_S_W-1:0] hx,
    input  logic signed [HIP_S_W-1:0] hy,
    input  logic signed [HIP_S_W-1:0] hz,
    output logic signed [ACC_W-1:0]   acc
);

    logic signed [TRIG_W-1:0] sr_reg, cr_reg, sp_reg, cp_reg, sy_reg, cy_reg;
    logic signed [TRIG_W-1:0] t1_reg, t2_reg, tmp_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [TRIG_W-1:0] op_a, op_b;
    logic signed [2*TRIG_W-1:0] prod_full;
    logic signed [PROD_W-1:0] prod_rnd_sum;
    logic signed [TRIG_W-1:0] prod_rnd;
    logic signed [ACC_W-1:0]  prod_acc;

    // operand selection
    always_comb
    begin
        case (ctrl.uop.a)
            SA_CY:   op_a = cy_reg;
            SA_SY:   op_a = sy_reg;
            SA_CP:   op_a = cp_reg;
            SA_SP:   op_a = sp_reg;
            SA_T1:   op_a = t1_reg;
            SA_T2:   op_a = t2_reg;
            default: op_a = tmp_reg;
        endcase
        case (ctrl.uop.b)
            SB_SP:   op_b = sp_reg;
            SB_CP:   op_b = cp_reg;
            SB_SR:   op_b = sr_reg;
            SB_CR:   op_b = cr_reg;
            SB_HX:   op_b = TRIG_W'(hx);
            SB_HY:   op_b = TRIG_W'(hy);
            default: op_b = TRIG_W'(hz);
        endcase
    end

    assign prod_full    = op_a * op_b;
    assign prod_rnd_sum = prod_reg + (PROD_W'(1) <<< 29);
    assign prod_rnd     = prod_rnd_sum[PROD_W-1:30];
    assign prod_acc     = prod_reg[ACC_W-1:0];

    // trig load, multiply and accumulate
    always_ff @(posedge clk)
    begin
        if (trig_we)
        begin
            case (trig_sel)
                TRIG_ROLL:
                begin
                    sr_reg <= sin_val;
                    cr_reg <= cos_val;
                end
                TRIG_PITCH:
                begin
                    sp_reg <= sin_val;
                    cp_reg <= cos_val;
                end
                default:
                begin
                    sy_reg <= sin_val;
                    cy_reg <= cos_val;
                end
            endcase
        end
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_full[PROD_W-1:0];
        end
        if (ctrl.act_en)
        begin
            case (ctrl.uop.act)
                ACT_T1:         t1_reg  <= prod_rnd;
                ACT_T2:         t2_reg  <= prod_rnd;
                ACT_SET:        tmp_reg <= prod_rnd;
                ACT_ADD:        tmp_reg <= tmp_reg + prod_rnd;
                ACT_SUB:        tmp_reg <= tmp_reg - prod_rnd;
                ACT_ACC_FIRST:  acc_reg <= prod_acc;
                ACT_ACC:        acc_reg <= acc_reg + prod_acc;
                ACT_NACC_FIRST: acc_reg <= -prod_acc;
                default:        acc_reg <= acc_reg;
            endcase
        end
    end

    assign acc = acc_reg;

endmodule

// File: design/leg_vector_from_body_pose_unit.sv
// ----------------------------------------------------------------------------
// leg_vector_from_body_pose_unit
// Per leg: body rotation from roll, pitch, yaw, rotated hip offset, and
// foot - (base + shift + R * hip), saturated.
// ----------------------------------------------------------------------------
// One pose transaction yields one leg vector transaction; the leg index comes
// from an internal counter that wraps after the fourth leg. Each item makes
// three cordic runs (a start state, 24 steps and a done strobe) on one shared
// cordic, then 23 steps on one shared 34x34 multiplier, each a multiply and
// an accumulate state, plus three row finishes. The block takes no new item
// until the result has been placed in the output register, and the last row
// finish waits while that register still holds a result the consumer has not
// taken. Configuration writes are always taken and should only be issued
// while the block is idle.
module leg_vector_from_body_pose_unit
    import lvbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    lvbp_pose_if.sink   pose,
    lvbp_leg_if.source  leg,
    lvbp_cfg_if.sink    cfg
);

    typedef enum logic [4:0] {
        S_IDLE       = 5'b00001,
        S_TRIG_START = 5'b00010,
        S_TRIG_WAIT  = 5'b00100,
        S_MUL        = 5'b01000,
        S_ACT        = 5'b10000
    } state_t;

    state_t                     state_reg, state_next;
    logic [1:0]                 trig_idx_reg, trig_idx_next;
    logic [PC_W-1:0]            pc_reg, pc_next;
    logic [LEG_W-1:0]           leg_cnt_reg, leg_cnt_next;
    logic [LEG_W-1:0]           leg_num_reg;
    logic [HIP_U_W-1:0]         hip_fwd_reg;
    logic [HIP_U_W-1:0]         hip_lat_reg;
    logic signed [HIP_S_W-1:0]  hip_vert_reg;
    logic signed [ANG_W-1:0]    roll_reg, pitch_reg, yaw_reg;
    logic signed [OFF_W-1:0]    off_x_reg, off_y_reg, off_z_reg;
    logic signed [POS_W-1:0]    vx_reg, vy_reg;
    logic                       clip_reg;
    logic                       out_valid_reg;
    logic [LEG_W-1:0]           out_leg_reg;
    logic signed [POS_W-1:0]    out_x_reg, out_y_reg, out_z_reg;
    logic                       out_last_reg, out_clip_reg;

    logic                       in_acc;
    logic                       cordic_start, cordic_done;
    logic signed [ANG_W-1:0]    cordic_angle;
    logic signed [TRIG_W-1:0]   sin_val, cos_val;
    mac_ctrl_t                  mac_ctrl;
    uop_t                       uop;
    logic signed [HIP_S_W-1:0]  hx, hy;
    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    acc_rnd;
    logic signed [ROT_W-1:0]    rot;
    logic signed [OFF_W-1:0]    off_sel;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [POS_W-1:0]    sat_val;
    logic                       sat_hit;
    logic                       fin_step, fin_last, out_free;

    assign in_acc    = pose.valid && pose.ready;
    assign pose.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign uop       = ucode(pc_reg);
    assign out_free  = !out_valid_reg || leg.ready;
    assign fin_step  = (state_reg == S_MUL) &&
                       (uop.act == ACT_FIN0 || uop.act == ACT_FIN1 || uop.act == ACT_FIN2);
    assign fin_last  = fin_step && (uop.act == ACT_FIN2) && out_free;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hip_fwd_reg  <= HIP_U_W'(53477);
            hip_lat_reg  <= HIP_U_W'(11141);
            hip_vert_reg <= -HIP_S_W'(6226);
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_HIP_FORWARD:  hip_fwd_reg  <= cfg.data[HIP_U_W-1:0];
                REG_HIP_LATERAL:  hip_lat_reg  <= cfg.data[HIP_U_W-1:0];
                REG_HIP_VERTICAL: hip_vert_reg <= cfg.data[HIP_S_W-1:0];
                default:          hip_fwd_reg  <= hip_fwd_reg;
            endcase
        end
    end

    // hip offset mirrored per leg
    assign hx = leg_num_reg[1] ? -$signed({1'b0, hip_fwd_reg}) : $signed({1'b0, hip_fwd_reg});
    assign hy = leg_num_reg[0] ? -$signed({1'b0, hip_lat_reg}) : $signed({1'b0, hip_lat_reg});

    // angle feed to the cordic
    always_comb
    begin
        case (trig_idx_reg)
            TRIG_ROLL:  cordic_angle = roll_reg;
            TRIG_PITCH: cordic_angle = pitch_reg;
            default:    cordic_angle = yaw_reg;
        endcase
    end

    assign cordic_start = (state_reg == S_TRIG_START);

    lvbp_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .angle   (cordic_angle),
        .done    (cordic_done),
        .sin_val (sin_val),
        .cos_val (cos_val)
    );

    assign mac_ctrl.mul_en = (state_reg == S_MUL) && !fin_step;
    assign mac_ctrl.act_en = (state_reg == S_ACT);
    assign mac_ctrl.uop    = uop;

    lvbp_mac u_mac (
        .clk      (clk),
        .ctrl     (mac_ctrl),
        .trig_we  (cordic_done),
        .trig_sel (trig_idx_reg),
        .sin_val  (sin_val),
        .cos_val  (cos_val),
        .hx       (hx),
        .hy       (hy),
        .hz       (hip_vert_reg),
        .acc      (acc)
    );

    // row finish: round, subtract from offset, saturate
    assign acc_rnd = acc + (ACC_W'(1) <<< 29);
    assign rot     = acc_rnd[ACC_W-1:30];
    always_comb
    begin
        case (uop.act)
            ACT_FIN0: off_sel = off_x_reg;
            ACT_FIN1: off_sel = off_y_reg;
            default:  off_sel = off_z_reg;
        endcase
        diff = DIFF_W'(off_sel) - DIFF_W'(rot);
        if (diff > DIFF_W'(64'sh7FFFFFFF))
        begin
            sat_val = 32'sh7FFFFFFF;
            sat_hit = 1'b1;
        end
        else if (diff < -DIFF_W'(64'sh80000000))
        begin
            sat_val = 32'sh80000000;
            sat_hit = 1'b1;
        end
        else
        begin
            sat_val = diff[POS_W-1:0];
            sat_hit = 1'b0;
        end
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        trig_idx_next = trig_idx_reg;
        pc_next       = pc_reg;
        leg_cnt_next  = leg_cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next    = S_TRIG_START;
                    trig_idx_next = TRIG_ROLL;
                    leg_cnt_next  = (leg_cnt_reg >= LEG_LAST) ? '0 : leg_cnt_reg + 1'b1;
                end
            end
            S_TRIG_START:
            begin
                state_next = S_TRIG_WAIT;
            end
            S_TRIG_WAIT:
            begin
                if (cordic_done)
                begin
                    trig_idx_next = trig_idx_reg + 1'b1;
                    if (trig_idx_reg == TRIG_YAW)
                    begin
                        state_next = S_MUL;
                        pc_next    = '0;
                    end
                    else
                    begin
                        state_next = S_TRIG_START;
                    end
                end
            end
            S_MUL:
            begin
                if (fin_step)
                begin
                    if (uop.act != ACT_FIN2)
                    begin
                        pc_next = pc_reg + 1'b1;
                    end
                    else if (out_free)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_ACT;
                end
            end
            S_ACT:
            begin
                pc_next    = pc_reg + 1'b1;
                state_next = S_MUL;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            trig_idx_reg  <= '0;
            pc_reg        <= '0;
            leg_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            trig_idx_reg <= trig_idx_next;
            pc_reg       <= pc_next;
            leg_cnt_reg  <= leg_cnt_next;
            if (fin_last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (leg.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // input capture, row results and output register
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            leg_num_reg <= leg_cnt_reg;
            roll_reg    <= pose.roll;
            pitch_reg   <= pose.pitch;
            yaw_reg     <= pose.yaw;
            off_x_reg   <= OFF_W'(pose.foot_x) - OFF_W'(pose.base_x) - OFF_W'(pose.shift_x);
            off_y_reg   <= OFF_W'(pose.foot_y) - OFF_W'(pose.base_y) - OFF_W'(pose.shift_y);
            off_z_reg   <= OFF_W'(pose.foot_z) - OFF_W'(pose.base_z) - OFF_W'(pose.shift_z);
        end
        if (fin_step && uop.act == ACT_FIN0)
        begin
            vx_reg   <= sat_val;
            clip_reg <= sat_hit;
        end
        if (fin_step && uop.act == ACT_FIN1)
        begin
            vy_reg   <= sat_val;
            clip_reg <= clip_reg | sat_hit;
        end
        if (fin_last)
        begin
            out_leg_reg  <= leg_num_reg;
            out_x_reg    <= vx_reg;
            out_y_reg    <= vy_reg;
            out_z_reg    <= sat_val;
            out_last_reg <= (leg_num_reg == LEG_LAST);
            out_clip_reg <= clip_reg | sat_hit;
        end
    end

    assign leg.valid      = out_valid_reg;
    assign leg.leg_number = out_leg_reg;
    assign leg.leg_x      = out_x_reg;
    assign leg.leg_y      = out_y_reg;
    assign leg.leg_z      = out_z_reg;
    assign leg.last_leg   = out_last_reg;
    assign leg.clipped    = out_clip_reg;

endmodule
